### rtl/window_variance_settling_detector_assert.svh
`ifndef WINDOW_VARIANCE_SETTLING_DETECTOR_ASSERT_SVH
`define WINDOW_VARIANCE_SETTLING_DETECTOR_ASSERT_SVH

// Check a consequent in the same cycle as its antecedent.
`define WVSD_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequent in the cycle after its antecedent.
`define WVSD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/wvsd_pkg.sv
package wvsd_pkg;

    // Field and accumulator widths
    localparam int DATA_W      = 32;
    localparam int COUNT_W     = 9;
    localparam int THRESH_W    = 31;
    localparam int TIME_W      = 32;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 32;
    localparam int SUM_W       = DATA_W + COUNT_W;
    localparam int TSQ_W       = 2 * THRESH_W;
    localparam int SQ_W        = 2 * DATA_W + COUNT_W;

    localparam int WINDOW_MAX_DEFAULT = 256;

    localparam logic [COUNT_W-1:0]  SETTLE_MIN_COUNT  = 9'd8;
    localparam logic [COUNT_W-1:0]  WINDOW_SIZE_RESET = 9'd256;
    localparam logic [THRESH_W-1:0] THRESH_RESET      = 31'd10;
    localparam logic [TIME_W-1:0]   TIMEOUT_RESET     = 32'd5000;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_WINDOW_SIZE      = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SETTLE_THRESHOLD = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_TIMEOUT_LIMIT    = 2'd2;

    typedef enum logic [1:0] {
        ST_COLLECTING = 2'd0,
        ST_SETTLED    = 2'd1,
        ST_TIMEOUT    = 2'd2
    } status_t;

    typedef enum logic {
        OP_PUSH    = 1'b0,
        OP_RESTART = 1'b1
    } opcode_t;

    typedef struct packed {
        opcode_t                   opcode;
        logic signed [DATA_W-1:0]  sample;
        logic        [TIME_W-1:0]  elapsed_time;
    } req_t;

    typedef struct packed {
        status_t                   status;
        logic signed [DATA_W-1:0]  mean_value;
        logic        [COUNT_W-1:0] held_count;
    } res_t;

endpackage

### rtl/window_variance_settling_detector.sv
// Sliding-window variance settling detector.
// Request channel (req_valid / req_stall / req_data): a push request stores the
// sample in the circular window and produces one result; a restart request
// clears the fill count and write position and produces none.
// Result channel (res_valid / res_stall / res_data): status, truncated mean
// and the number of samples held. The result sits in an output register, so
// the next request is taken while the result waits on a stalled receiver;
// the block holds its last step only when a second result is ready before
// the first is taken.
// Steps per push request, with n the samples held: a summing pass over the n
// samples in the sample memory (one read port), a bit-serial mean division,
// a squared-deviation pass over the n samples, the limit product and the
// compare; the result is then loaded into the output register, and the block
// takes no new request until the result has been loaded.
// Configuration writes (cfg_we / cfg_index / cfg_data) are taken at any edge
// and are meant for an idle block. Reset loads the default configuration and
// clears the fill count and write position; sample memory is left as is.
module window_variance_settling_detector
    import wvsd_pkg::*;
#(
    parameter int WINDOW_MAX = WINDOW_MAX_DEFAULT
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   req_valid,
    output logic                   req_stall,
    input  req_t                   req_data,
    output logic                   res_valid,
    input  logic                   res_stall,
    output res_t                   res_data,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int POS_W    = $clog2(WINDOW_MAX);
    localparam int COUNT_MAX = (1 << COUNT_W) - 1;
    localparam int SIZE_CAP = (WINDOW_MAX < COUNT_MAX) ? WINDOW_MAX : COUNT_MAX;
    localparam int CMP_W    = ((POS_W > COUNT_W) ? POS_W : COUNT_W) + 1;
    localparam logic [COUNT_W-1:0] SIZE_CAP_C = COUNT_W'(SIZE_CAP);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_SUM    = 6'b000010,
        S_DIV    = 6'b000100,
        S_VAR    = 6'b001000,
        S_LIMIT  = 6'b010000,
        S_DECIDE = 6'b100000
    } state_t;

    state_t                   state_reg, state_next;
    logic [COUNT_W-1:0]       window_size_reg, window_size_next;
    logic [THRESH_W-1:0]      thresh_reg, thresh_next;
    logic [TIME_W-1:0]        timeout_reg, timeout_next;
    logic [POS_W-1:0]         pos_reg, pos_next;
    logic [COUNT_W-1:0]       count_reg, count_next;
    logic [COUNT_W-1:0]       rd_idx_reg, rd_idx_next;
    logic                     rd_vld_reg, rd_vld_next;
    logic                     mag_vld_reg, mag_vld_next;
    logic                     sqr_vld_reg, sqr_vld_next;
    logic                     res_valid_reg, res_valid_next;

    logic [TIME_W-1:0]        elapsed_reg, elapsed_next;
    logic [TSQ_W-1:0]         tsq_reg, tsq_next;
    logic signed [SUM_W-1:0]  sum_reg, sum_next;
    logic [DATA_W-1:0]        mean_reg, mean_next;
    logic [DATA_W-1:0]        mag_reg, mag_next;
    logic [2*DATA_W-1:0]      sqr_reg, sqr_next;
    logic [SQ_W-1:0]          sq_acc_reg, sq_acc_next;
    logic [SQ_W-1:0]          limit_reg, limit_next;
    res_t                     res_data_reg, res_data_next;

    logic                     req_accept;
    logic [COUNT_W-1:0]       eff_size;
    logic [CMP_W-1:0]         pos_inc;
    logic                     rd_issue;
    logic                     mem_we;
    logic [DATA_W-1:0]        mem_rdata;
    logic signed [DATA_W-1:0] rd_sample;
    logic signed [DATA_W:0]   dev;
    logic signed [DATA_W:0]   dev_neg;
    logic [SUM_W-1:0]         sum_mag;
    logic                     div_start;
    logic                     div_done;
    logic [SUM_W-1:0]         div_quot;
    logic [DATA_W-1:0]        quot_low;
    logic                     settled;

    assign req_stall  = (state_reg != S_IDLE);
    assign req_accept = req_valid && !req_stall;
    assign mem_we     = req_accept && (req_data.opcode == OP_PUSH);
    assign rd_issue   = (state_reg inside {S_SUM, S_VAR}) && (rd_idx_reg < count_reg);
    assign rd_sample  = mem_rdata;

    // Clamp the configured window to 1 .. capacity
    assign eff_size = (window_size_reg == '0) ? COUNT_W'(1) :
                      ((window_size_reg > SIZE_CAP_C) ? SIZE_CAP_C : window_size_reg);
    assign pos_inc  = CMP_W'(pos_reg) + CMP_W'(1);

    // Deviation magnitude for the squaring stage
    assign dev     = {rd_sample[DATA_W-1], rd_sample} - {mean_reg[DATA_W-1], mean_reg};
    assign dev_neg = -dev;

    assign sum_mag  = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
    assign quot_low = div_quot[DATA_W-1:0];
    assign settled  = (count_reg >= SETTLE_MIN_COUNT) && (sq_acc_reg < limit_reg);

    wvsd_sample_mem #(
        .DEPTH (WINDOW_MAX)
    ) u_sample_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (pos_reg),
        .wdata (req_data.sample),
        .re    (rd_issue),
        .raddr (POS_W'(rd_idx_reg)),
        .rdata (mem_rdata)
    );

    wvsd_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_mag),
        .divisor  (count_reg),
        .done     (div_done),
        .quotient (div_quot)
    );

    // Sequencer and passes over the sample memory
    always_comb
    begin
        state_next       = state_reg;
        window_size_next = window_size_reg;
        thresh_next      = thresh_reg;
        timeout_next     = timeout_reg;
        pos_next         = pos_reg;
        count_next       = count_reg;
        rd_idx_next      = rd_idx_reg;
        rd_vld_next      = rd_issue;
        mag_vld_next     = (state_reg == S_VAR) && rd_vld_reg;
        sqr_vld_next     = mag_vld_reg;
        res_valid_next   = res_valid_reg && res_stall;
        elapsed_next     = elapsed_reg;
        tsq_next         = tsq_reg;
        sum_next         = sum_reg;
        mean_next        = mean_reg;
        mag_next         = dev[DATA_W] ? dev_neg[DATA_W-1:0] : dev[DATA_W-1:0];
        sqr_next         = (2*DATA_W)'(mag_reg) * (2*DATA_W)'(mag_reg);
        sq_acc_next      = sq_acc_reg;
        limit_next       = limit_reg;
        res_data_next    = res_data_reg;
        div_start        = 1'b0;

        // Take configuration writes
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_WINDOW_SIZE:      window_size_next = cfg_data[COUNT_W-1:0];
                CFG_SETTLE_THRESHOLD: thresh_next      = cfg_data[THRESH_W-1:0];
                CFG_TIMEOUT_LIMIT:    timeout_next     = cfg_data[TIME_W-1:0];
                default:              ;
            endcase
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req_accept)
                begin
                    if (req_data.opcode == OP_RESTART)
                    begin
                        pos_next   = '0;
                        count_next = '0;
                    end
                    else
                    begin
                        // Sample is written this edge; advance position and fill
                        pos_next     = (pos_inc >= CMP_W'(eff_size)) ? '0 : pos_inc[POS_W-1:0];
                        if (count_reg < eff_size)
                        begin
                            count_next = count_reg + COUNT_W'(1);
                        end
                        elapsed_next = req_data.elapsed_time;
                        tsq_next     = TSQ_W'(thresh_reg) * TSQ_W'(thresh_reg);
                        rd_idx_next  = '0;
                        sum_next     = '0;
                        state_next   = S_SUM;
                    end
                end
            end

            S_SUM:
            begin
                if (rd_issue)
                begin
                    rd_idx_next = rd_idx_reg + COUNT_W'(1);
                end
                if (rd_vld_reg)
                begin
                    sum_next = sum_reg + SUM_W'(rd_sample);
                end
                if (!rd_issue && !rd_vld_reg)
                begin
                    div_start  = 1'b1;
                    state_next = S_DIV;
                end
            end

            S_DIV:
            begin
                if (div_done)
                begin
                    mean_next   = sum_reg[SUM_W-1] ? -quot_low : quot_low;
                    rd_idx_next = '0;
                    sq_acc_next = '0;
                    state_next  = S_VAR;
                end
            end

            S_VAR:
            begin
                if (rd_issue)
                begin
                    rd_idx_next = rd_idx_reg + COUNT_W'(1);
                end
                if (sqr_vld_reg)
                begin
                    sq_acc_next = sq_acc_reg + SQ_W'(sqr_reg);
                end
                if (!rd_issue && !rd_vld_reg && !mag_vld_reg && !sqr_vld_reg)
                begin
                    state_next = S_LIMIT;
                end
            end

            S_LIMIT:
            begin
                // sq / n < t^2 exactly when sq < n * t^2
                limit_next = SQ_W'(tsq_reg) * SQ_W'(count_reg);
                state_next = S_DECIDE;
            end

            S_DECIDE:
            begin
                // Hold until the output register is free
                if (!res_valid_reg || !res_stall)
                begin
                    res_valid_next             = 1'b1;
                    res_data_next.mean_value   = mean_reg;
                    res_data_next.held_count   = count_reg;
                    if (settled)
                    begin
                        res_data_next.status = ST_SETTLED;
                    end
                    else if (elapsed_reg >= timeout_reg)
                    begin
                        res_data_next.status = ST_TIMEOUT;
                    end
                    else
                    begin
                        res_data_next.status = ST_COLLECTING;
                    end
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            window_size_reg <= WINDOW_SIZE_RESET;
            thresh_reg      <= THRESH_RESET;
            timeout_reg     <= TIMEOUT_RESET;
            pos_reg         <= '0;
            count_reg       <= '0;
            rd_idx_reg      <= '0;
            rd_vld_reg      <= 1'b0;
            mag_vld_reg     <= 1'b0;
            sqr_vld_reg     <= 1'b0;
            res_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            window_size_reg <= window_size_next;
            thresh_reg      <= thresh_next;
            timeout_reg     <= timeout_next;
            pos_reg         <= pos_next;
            count_reg       <= count_next;
            rd_idx_reg      <= rd_idx_next;
            rd_vld_reg      <= rd_vld_next;
            mag_vld_reg     <= mag_vld_next;
            sqr_vld_reg     <= sqr_vld_next;
            res_valid_reg   <= res_valid_next;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        elapsed_reg  <= elapsed_next;
        tsq_reg      <= tsq_next;
        sum_reg      <= sum_next;
        mean_reg     <= mean_next;
        mag_reg      <= mag_next;
        sqr_reg      <= sqr_next;
        sq_acc_reg   <= sq_acc_next;
        limit_reg    <= limit_next;
        res_data_reg <= res_data_next;
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

endmodule

### rtl/wvsd_sample_mem.sv
module wvsd_sample_mem
    import wvsd_pkg::*;
#(
    parameter int DEPTH = WINDOW_MAX_DEFAULT,
    localparam int ADDR_W = $clog2(DEPTH)
)
(
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem_array [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_array[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_array[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/wvsd_div.sv
module wvsd_div
    import wvsd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [SUM_W-1:0]   dividend,
    input  logic [COUNT_W-1:0] divisor,
    output logic               done,
    output logic [SUM_W-1:0]   quotient
);

    localparam int STEP_W = $clog2(SUM_W + 1);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(SUM_W - 1);

    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic [COUNT_W-1:0] rem_reg, rem_next;
    logic [SUM_W-1:0]   dq_reg, dq_next;
    logic [COUNT_W-1:0] divisor_reg, divisor_next;
    logic [COUNT_W:0]   trial;
    logic [COUNT_W:0]   diff;

    // One quotient bit per cycle, restoring form
    always_comb
    begin
        busy_next    = busy_reg;
        done_next    = 1'b0;
        step_next    = step_reg;
        rem_next     = rem_reg;
        dq_next      = dq_reg;
        divisor_next = divisor_reg;
        trial        = {rem_reg, dq_reg[SUM_W-1]};
        diff         = trial - {1'b0, divisor_reg};

        if (start)
        begin
            busy_next    = 1'b1;
            step_next    = '0;
            rem_next     = '0;
            dq_next      = dividend;
            divisor_next = divisor;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, divisor_reg})
            begin
                rem_next = diff[COUNT_W-1:0];
                dq_next  = {dq_reg[SUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[COUNT_W-1:0];
                dq_next  = {dq_reg[SUM_W-2:0], 1'b0};
            end
            step_next = step_reg + STEP_W'(1);
            if (step_reg == LAST_STEP)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        rem_reg     <= rem_next;
        dq_reg      <= dq_next;
        divisor_reg <= divisor_next;
    end

    assign done     = done_reg;
    assign quotient = dq_reg;

endmodule

### rtl/wvsd_checker.sv
`include "window_variance_settling_detector_assert.svh"

module wvsd_checker
    import wvsd_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic req_valid,
    input logic req_stall,
    input req_t req_data,
    input logic res_valid,
    input logic res_stall,
    input res_t res_data
);

    // Hold a stalled result
    `WVSD_ASSERT_NEXT(a_res_hold, clk, rst_n, res_valid && res_stall,
        res_valid && $stable(res_data), "stalled result changed")

    // Stall requests while a push is being evaluated
    `WVSD_ASSERT_NEXT(a_push_busy, clk, rst_n,
        req_valid && !req_stall && req_data.opcode == OP_PUSH, req_stall,
        "push request not followed by busy")

    // Leave the block free for a new request after a restart
    `WVSD_ASSERT_NEXT(a_restart_quick, clk, rst_n,
        req_valid && !req_stall && req_data.opcode == OP_RESTART, !req_stall,
        "restart request left block busy")

    // Report at least one held sample
    `WVSD_ASSERT_SAME(a_res_count, clk, rst_n, res_valid, res_data.held_count != '0,
        "result with empty window")

    // Settle only on a full enough window
    `WVSD_ASSERT_SAME(a_settle_min, clk, rst_n, res_valid && res_data.status == ST_SETTLED,
        res_data.held_count >= SETTLE_MIN_COUNT, "settled with too few samples")

endmodule

bind window_variance_settling_detector wvsd_checker u_wvsd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_data  (req_data),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_data  (res_data)
);
